// File: rtl/core/qet_pkg.sv
// Shared types, character codes and helper functions of the quoted escape tokenizer.
package qet_pkg;

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_PLAIN   = 2'd1,
    MODE_QUOTED  = 2'd2
  } scan_mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OPEN_QUOTE = 2'd1,
    STATUS_DANGLING  = 2'd2
  } line_status_e;

  localparam logic [7:0] CharN         = 8'h6E;
  localparam logic [7:0] CharT         = 8'h74;
  localparam logic [7:0] CharLf        = 8'h0A;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharCr        = 8'h0D;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;

  typedef struct packed {
    logic         has_char;
    logic [7:0]   char_out;
    logic         token_end;
    logic         line_done;
    line_status_e line_status;
  } result_t;

  // Space, TAB, LF, VT, FF, CR.
  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  function automatic logic [7:0] decode_escape(input logic [7:0] c);
    if (c == CharN) begin
      decode_escape = CharLf;
    end else if (c == CharT) begin
      decode_escape = CharTab;
    end else begin
      decode_escape = c;
    end
  endfunction

endpackage

// File: rtl/core/qet_in_if.sv
// Input channel of the tokenizer: one line byte or an end-of-line mark per transfer.
interface qet_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_line;

  modport source (output valid, output char_in, output end_of_line, input ready);
  modport sink   (input valid, input char_in, input end_of_line, output ready);
endinterface

// File: rtl/core/qet_out_if.sv
// Result channel of the tokenizer: decoded characters, token ends and line status.
interface qet_out_if;
  logic       valid;
  logic       ready;
  logic       has_char;
  logic [7:0] char_out;
  logic       token_end;
  logic       line_done;
  logic [1:0] line_status;

  modport source (output valid, output has_char, output char_out, output token_end,
                  output line_done, output line_status, input ready);
  modport sink   (input valid, input has_char, input char_out, input token_end,
                  input line_done, input line_status, output ready);
endinterface

// File: rtl/core/quoted_escape_tokenizer.sv
// Top level of the quoted escape tokenizer: input register, decode logic, result register.
//
// Usage: feed a text line on in_i one byte per transfer and close it with a transfer
// that has end_of_line set (char_in is then ignored). Tokens split at whitespace
// outside double quotes; a backslash escapes the next byte (n -> LF, t -> TAB).
// out_o carries at most one result per input transfer: a decoded character
// (has_char), a token end (token_end), or the end-of-line report (line_done with
// line_status 0 ok, 1 unterminated quote, 2 dangling backslash). Bytes that only
// change state (blank between tokens, opening quote, backslash) yield no result.
// Path: an accepted byte is held in the input register, decoded, and its result
// is registered in the result register that drives out_o. Throughput is one byte
// per cycle while no result waits on a stalled receiver, set by the single decode
// step between the two registers; the scan mode and escape flag update in that step.
// Reset clears both pipeline registers and returns the scanner to between tokens
// with no escape pending. When the receiver stalls, the result register holds and
// a new byte is still taken into the input register; only when both are full and a
// result is pending does in_i.ready drop.
module quoted_escape_tokenizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  qet_in_if.sink             in_i,
  qet_out_if.source          out_o
);

  logic                   in_valid_q;
  logic [7:0]             char_q;
  logic                   eol_q;

  qet_pkg::scan_mode_e    mode_q, mode_d;
  logic                   esc_q, esc_d;

  logic                   res_valid_q;
  qet_pkg::result_t       res_q, res_d;
  logic                   emit;
  logic                   res_free;
  logic                   advance;

  // Decode one byte against the current scan state.
  always_comb begin
    qet_pkg::scan_mode_e mode;
    mode   = mode_q;
    mode_d = mode_q;
    esc_d  = esc_q;
    emit   = 1'b0;
    res_d  = '{has_char: 1'b0, char_out: 8'h00, token_end: 1'b0, line_done: 1'b0,
               line_status: qet_pkg::STATUS_OK};

    unique case (mode_q)
      qet_pkg::MODE_PLAIN:  mode = qet_pkg::MODE_PLAIN;
      qet_pkg::MODE_QUOTED: mode = qet_pkg::MODE_QUOTED;
      default:              mode = qet_pkg::MODE_BETWEEN;
    endcase

    priority if (eol_q) begin
      emit            = 1'b1;
      res_d.line_done = 1'b1;
      if (esc_q) begin
        res_d.line_status = qet_pkg::STATUS_DANGLING;
      end else if (mode == qet_pkg::MODE_QUOTED) begin
        res_d.line_status = qet_pkg::STATUS_OPEN_QUOTE;
      end else if (mode == qet_pkg::MODE_PLAIN) begin
        res_d.token_end = 1'b1;
      end
      mode_d = qet_pkg::MODE_BETWEEN;
      esc_d  = 1'b0;
    end else if (esc_q) begin
      emit           = 1'b1;
      res_d.has_char = 1'b1;
      res_d.char_out = qet_pkg::decode_escape(char_q);
      esc_d          = 1'b0;
      mode_d         = mode;
    end else if (mode == qet_pkg::MODE_BETWEEN && qet_pkg::is_blank(char_q)) begin
      mode_d = qet_pkg::MODE_BETWEEN;
    end else if (mode == qet_pkg::MODE_BETWEEN && char_q == qet_pkg::CharQuote) begin
      mode_d = qet_pkg::MODE_QUOTED;
    end else if (mode == qet_pkg::MODE_PLAIN && qet_pkg::is_blank(char_q)) begin
      emit            = 1'b1;
      res_d.token_end = 1'b1;
      mode_d          = qet_pkg::MODE_BETWEEN;
    end else if (char_q == qet_pkg::CharBackslash) begin
      // A backslash between tokens opens an unquoted token.
      esc_d  = 1'b1;
      mode_d = (mode == qet_pkg::MODE_QUOTED) ? qet_pkg::MODE_QUOTED : qet_pkg::MODE_PLAIN;
    end else if (mode == qet_pkg::MODE_QUOTED && char_q == qet_pkg::CharQuote) begin
      emit            = 1'b1;
      res_d.token_end = 1'b1;
      mode_d          = qet_pkg::MODE_BETWEEN;
    end else begin
      emit           = 1'b1;
      res_d.has_char = 1'b1;
      res_d.char_out = char_q;
      mode_d         = (mode == qet_pkg::MODE_QUOTED) ? qet_pkg::MODE_QUOTED :
                                                        qet_pkg::MODE_PLAIN;
    end
  end

  assign res_free   = !res_valid_q || out_o.ready;
  assign advance    = in_valid_q && (!emit || res_free);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      char_q <= in_i.char_in;
      eol_q  <= in_i.end_of_line;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= qet_pkg::MODE_BETWEEN;
      esc_q  <= 1'b0;
    end else if (advance) begin
      mode_q <= mode_d;
      esc_q  <= esc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= advance && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.has_char    = res_q.has_char;
  assign out_o.char_out    = res_q.char_out;
  assign out_o.token_end   = res_q.token_end;
  assign out_o.line_done   = res_q.line_done;
  assign out_o.line_status = res_q.line_status;

  // A pending escape always belongs to an open token.
  a_esc_in_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (mode_q != qet_pkg::MODE_BETWEEN))
    else $error("escape pending outside a token");

  a_char_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_q.has_char && (res_q.line_done || res_q.token_end)))
    else $error("character result mixed with token or line end");

  a_status_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.line_done) |-> (res_q.line_status == qet_pkg::STATUS_OK))
    else $error("line status set without line end");

  a_eol_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && eol_q) |=> (mode_q == qet_pkg::MODE_BETWEEN && !esc_q))
    else $error("scanner not idle after end of line");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Testbench of the quoted escape tokenizer: directed and random lines against a byte predictor.
module testbench;

  localparam int CycleLimit = 500000;
  localparam int DrainCycles = 6;
  localparam logic [7:0] CharVt = 8'h0B;
  localparam logic [7:0] CharFf = 8'h0C;

  logic clk_i;
  logic rst_ni;

  qet_in_if  in_ch ();
  qet_out_if out_ch ();

  quoted_escape_tokenizer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Predictor state
  qet_pkg::scan_mode_e scan_st = qet_pkg::MODE_BETWEEN;
  logic                esc_pend = 1'b0;
  qet_pkg::result_t    token_results_q[$];
  qet_pkg::result_t    exp_res;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;
  int n_bytes = 0;
  int n_lines = 0;
  int n_chars = 0;
  int n_token_ends = 0;
  int n_status[3] = '{0, 0, 0};
  int failures = 0;
  int cycles = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic is_space(input logic [7:0] c);
    return (c == qet_pkg::CharSpace) || ((c >= qet_pkg::CharTab) && (c <= qet_pkg::CharCr));
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // Advance the scanner by one byte or end of line; return 1 when a result is due.
  function automatic logic tokenize_byte(input logic [7:0] c, input logic eol,
                                         output qet_pkg::result_t res);
    qet_pkg::scan_mode_e mode;
    res = '0;
    mode = (scan_st == qet_pkg::MODE_PLAIN || scan_st == qet_pkg::MODE_QUOTED) ?
           scan_st : qet_pkg::MODE_BETWEEN;
    if (eol) begin
      res.line_done = 1'b1;
      if (esc_pend) begin
        res.line_status = qet_pkg::STATUS_DANGLING;
      end else if (mode == qet_pkg::MODE_QUOTED) begin
        res.line_status = qet_pkg::STATUS_OPEN_QUOTE;
      end else begin
        res.token_end = (mode == qet_pkg::MODE_PLAIN);
      end
      scan_st = qet_pkg::MODE_BETWEEN;
      esc_pend = 1'b0;
      return 1'b1;
    end
    if (esc_pend) begin
      esc_pend = 1'b0;
      scan_st = mode;
      res.has_char = 1'b1;
      res.char_out = (c == qet_pkg::CharN) ? qet_pkg::CharLf :
                     (c == qet_pkg::CharT) ? qet_pkg::CharTab : c;
      return 1'b1;
    end
    if (mode == qet_pkg::MODE_BETWEEN) begin
      if (is_space(c)) begin
        scan_st = qet_pkg::MODE_BETWEEN;
        return 1'b0;
      end
      if (c == qet_pkg::CharQuote) begin
        scan_st = qet_pkg::MODE_QUOTED;
        return 1'b0;
      end
      mode = qet_pkg::MODE_PLAIN;
    end
    if (mode == qet_pkg::MODE_PLAIN && is_space(c)) begin
      scan_st = qet_pkg::MODE_BETWEEN;
      res.token_end = 1'b1;
      return 1'b1;
    end
    scan_st = mode;
    if (c == qet_pkg::CharBackslash) begin
      esc_pend = 1'b1;
      return 1'b0;
    end
    if (mode == qet_pkg::MODE_QUOTED && c == qet_pkg::CharQuote) begin
      scan_st = qet_pkg::MODE_BETWEEN;
      res.token_end = 1'b1;
      return 1'b1;
    end
    res.has_char = 1'b1;
    res.char_out = c;
    return 1'b1;
  endfunction

  task automatic send_item(input logic [7:0] c, input logic eol);
    int gap;
    qet_pkg::result_t res;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_in     <= c;
    in_ch.end_of_line <= eol;
    do @(posedge clk_i); while (!in_ch.ready);
    n_bytes++;
    if (tokenize_byte(c, eol, res)) token_results_q.push_back(res);
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(c, 1'b0);
  endtask

  // Close the line; the byte lane carries junk that must be ignored.
  task automatic send_eol();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Hold the input until every expected result has come out.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (token_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (is_space(c) || c == qet_pkg::CharQuote || c == qet_pkg::CharBackslash);
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return qet_pkg::CharSpace;
      1: return qet_pkg::CharTab;
      2: return qet_pkg::CharLf;
      3: return CharVt;
      4: return CharFf;
      default: return qet_pkg::CharCr;
    endcase
  endfunction

  function automatic logic [7:0] escaped_char();
    case ($urandom_range(0, 5))
      0: return qet_pkg::CharN;
      1: return qet_pkg::CharT;
      2: return qet_pkg::CharQuote;
      3: return qet_pkg::CharBackslash;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_escape();
    send_char(qet_pkg::CharBackslash);
    send_char(escaped_char());
  endtask

  task automatic send_well_formed_line();
    int n_tok;
    int len;
    repeat ($urandom_range(0, 2)) send_char(blank_char());
    n_tok = $urandom_range(0, 6);
    for (int t = 0; t < n_tok; t++) begin
      if (t > 0) repeat ($urandom_range(1, 3)) send_char(blank_char());
      if ($urandom_range(0, 99) < 40) begin
        send_char(qet_pkg::CharQuote);
        len = $urandom_range(0, 6);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 99) < 15) send_escape();
          else if ($urandom_range(0, 99) < 20) send_char(blank_char());
          else send_char(word_char());
        end
        send_char(qet_pkg::CharQuote);
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 99) < 15) send_escape();
          else if (k > 0 && $urandom_range(0, 99) < 10) send_char(qet_pkg::CharQuote);
          else send_char(word_char());
        end
      end
    end
    // Break some lines on purpose.
    case ($urandom_range(0, 9))
      0: send_char(qet_pkg::CharBackslash);
      1: begin
        send_char(blank_char());
        send_char(qet_pkg::CharQuote);
        repeat ($urandom_range(0, 3)) send_char(word_char());
      end
      default: repeat ($urandom_range(0, 1)) send_char(blank_char());
    endcase
    send_eol();
  endtask

  task automatic send_noise_line();
    repeat ($urandom_range(0, 12)) begin
      case ($urandom_range(0, 3))
        0: send_char(qet_pkg::CharQuote);
        1: send_char(qet_pkg::CharBackslash);
        2: send_char(blank_char());
        default: send_char(8'($urandom_range(1, 255)));
      endcase
    end
    send_eol();
  endtask

  task automatic send_random_lines(input int n_items);
    int stop_at;
    stop_at = n_bytes + n_items;
    while (n_bytes < stop_at) begin
      if ($urandom_range(0, 99) < 85) send_well_formed_line();
      else send_noise_line();
    end
  endtask

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      failures++;
    end
  endtask

  task automatic test_directed_lines();
    tx_idle_pct = 30;
    rx_stall_pct = 30;
    // Quoted token with a blank inside, empty quoted token, quoted token then plain token,
    // TAB, VT and FF between tokens, extreme bytes, token still open at end of line.
    send_text("a\t\"b \"\"\"x\"y");
    send_char(CharVt);
    send_char(CharFf);
    send_char(8'hFF);
    send_char(8'h01);
    send_eol();
    // Escapes outside and inside quotes, then a dangling backslash.
    send_text("\\n\\t");
    send_char(qet_pkg::CharCr);
    send_text("\"\\\"\\\\\"");
    send_char(qet_pkg::CharLf);
    send_char(qet_pkg::CharBackslash);
    send_eol();
    // Unterminated quote.
    send_text("\"q");
    send_eol();
    // Dangling backslash inside quotes wins over the open quote.
    send_text("\"\\");
    send_eol();
    drain_results();
  endtask

  task automatic test_random_mixed_idle();
    tx_idle_pct = 30;
    rx_stall_pct = 30;
    send_random_lines(600);
    drain_results();
  endtask

  task automatic test_receiver_stalls();
    tx_idle_pct = 0;
    rx_stall_pct = 60;
    send_random_lines(200);
    drain_results();
  endtask

  task automatic test_full_rate();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_random_lines(200);
    drain_results();
  endtask

  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold--;
    end else begin
      rx_hold = pick_gap(rx_stall_pct);
      out_ch.ready <= (rx_hold == 0);
      if (rx_hold > 0) rx_hold--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (token_results_q.size() == 0) begin
        $error("result with none expected: has_char %0b char_out 0x%02h token_end %0b %s",
               out_ch.has_char, out_ch.char_out, out_ch.token_end,
               $sformatf("line_done %0b line_status %0d", out_ch.line_done,
                         out_ch.line_status));
        failures++;
      end else begin
        exp_res = token_results_q.pop_front();
        compare_field("has_char", exp_res.has_char, out_ch.has_char);
        compare_field("char_out", exp_res.char_out, out_ch.char_out);
        compare_field("token_end", exp_res.token_end, out_ch.token_end);
        compare_field("line_done", exp_res.line_done, out_ch.line_done);
        compare_field("line_status", exp_res.line_status, out_ch.line_status);
        if (exp_res.has_char) n_chars++;
        if (exp_res.token_end) n_token_ends++;
        if (exp_res.line_done) begin
          n_lines++;
          n_status[exp_res.line_status]++;
        end
      end
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.char_in     <= '0;
    in_ch.end_of_line <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_lines();
    test_random_mixed_idle();
    test_receiver_stalls();
    test_full_rate();

    $display("Covered %0d transfers in %0d lines: %0d decoded characters, %0d token ends.",
             n_bytes, n_lines, n_chars, n_token_ends);
    $display("Line endings: %0d ok, %0d unterminated quote, %0d dangling backslash.",
             n_status[qet_pkg::STATUS_OK], n_status[qet_pkg::STATUS_OPEN_QUOTE],
             n_status[qet_pkg::STATUS_DANGLING]);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
